>>> rtl/core/ptb_pkg.sv
// ----------------------------------------------------------------------------
// ptb_pkg
// shared types, widths and codes of the piece table text buffer
// ----------------------------------------------------------------------------
`default_nettype none

package ptb_pkg;

   // sizes of the piece table and the byte stores
   localparam int MAX_PIECES = 64;
   localparam int ORIG_DEPTH = 4096;
   localparam int ADD_DEPTH  = 4096;

   // transaction field widths
   localparam int CMD_W    = 3;
   localparam int POS_W    = 14;
   localparam int COUNT_W  = 14;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 2;

   // derived widths
   localparam int IDX_W   = $clog2(MAX_PIECES);
   localparam int CNT_W   = IDX_W + 1;
   localparam int ORIG_AW = $clog2(ORIG_DEPTH);
   localparam int ADD_AW  = $clog2(ADD_DEPTH);
   localparam int ORIG_LW = ORIG_AW + 1;
   localparam int ADD_LW  = ADD_AW + 1;
   localparam int OFF_W   = (ORIG_AW > ADD_AW) ? ORIG_AW : ADD_AW;
   localparam int LEN_W   = OFF_W + 1;
   localparam int RD_W    = LEN_W + 1;
   localparam int ACC_W   = IDX_W + LEN_W + 1;

   // commands
   localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_STAGE  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_LENGTH = 3'd5;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_STORE_FULL = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE      = 2'd3;

   // cell operations
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_HOLD   = 3'd0;
   localparam logic [OP_W-1:0] OP_ROTATE = 3'd1;
   localparam logic [OP_W-1:0] OP_OPEN   = 3'd2;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
   localparam logic [OP_W-1:0] OP_WRITE  = 3'd4;

   typedef struct packed {
      logic             src;
      logic [OFF_W-1:0] off;
      logic [LEN_W-1:0] len;
   } piece_type;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [CNT_W-1:0] at;
      piece_type        wdata;
   } cell_ctrl_type;

endpackage

`default_nettype wire

>>> rtl/core/ptb_ram.sv
// ----------------------------------------------------------------------------
// ptb_ram
// single write port, single registered read port memory
// ----------------------------------------------------------------------------
`default_nettype none

module ptb_ram #(
   parameter int  DEPTH = 16,
   parameter int  WIDTH = 8,
   localparam int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/ptb_cell.sv
// ----------------------------------------------------------------------------
// ptb_cell
// one slot of the piece table, shifts to and from its neighbors
// ----------------------------------------------------------------------------
`default_nettype none

module ptb_cell (
   input  wire logic                       clock,
   input  wire ptb_pkg::cell_ctrl_type     ctrl,
   input  wire logic [ptb_pkg::IDX_W-1:0]  index,
   input  wire ptb_pkg::piece_type         left_piece,
   input  wire ptb_pkg::piece_type         right_piece,
   output ptb_pkg::piece_type              piece_q
);

   ptb_pkg::piece_type            piece_ff;
   ptb_pkg::piece_type            piece_in;
   logic [ptb_pkg::CNT_W-1:0]     my_idx;

   assign my_idx = {1'b0, index};

   always_comb begin
      piece_in = piece_ff;
      unique case (ctrl.op)
         ptb_pkg::OP_HOLD: begin
            piece_in = piece_ff;
         end
         ptb_pkg::OP_ROTATE: begin
            piece_in = right_piece;
         end
         ptb_pkg::OP_REMOVE: begin
            if (my_idx >= ctrl.at) begin
               piece_in = right_piece;
            end
         end
         ptb_pkg::OP_OPEN: begin
            if (my_idx > ctrl.at) begin
               piece_in = left_piece;
            end else if (my_idx == ctrl.at) begin
               piece_in = ctrl.wdata;
            end
         end
         ptb_pkg::OP_WRITE: begin
            if (my_idx == ctrl.at) begin
               piece_in = ctrl.wdata;
            end
         end
         default: begin
            piece_in = piece_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      piece_ff <= piece_in;
   end

   assign piece_q = piece_ff;

endmodule

`default_nettype wire

>>> rtl/core/ptb_chain.sv
// ----------------------------------------------------------------------------
// ptb_chain
// row of piece cells with a ring link for scanning through the head
// ----------------------------------------------------------------------------
`default_nettype none

module ptb_chain (
   input  wire logic                   clock,
   input  wire ptb_pkg::cell_ctrl_type ctrl,
   output ptb_pkg::piece_type          head
);

   ptb_pkg::piece_type q [ptb_pkg::MAX_PIECES];

   for (genvar j = 0; j < ptb_pkg::MAX_PIECES; j++) begin : g_cell
      ptb_pkg::piece_type left_p;
      ptb_pkg::piece_type right_p;

      if (j == 0) begin : g_first
         assign left_p = ctrl.wdata;
      end else begin : g_mid
         assign left_p = q[j-1];
      end

      // last cell wraps to the head so a full rotation restores the order
      if (j == ptb_pkg::MAX_PIECES - 1) begin : g_last
         assign right_p = q[0];
      end else begin : g_body
         assign right_p = q[j+1];
      end

      ptb_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .index       (ptb_pkg::IDX_W'(j)),
         .left_piece  (left_p),
         .right_piece (right_p),
         .piece_q     (q[j])
      );
   end

   assign head = q[0];

endmodule

`default_nettype wire

>>> rtl/core/piece_table_text_buffer.sv
// ----------------------------------------------------------------------------
// piece_table_text_buffer
// piece table text store: original and add byte stores plus a row of piece cells
// ----------------------------------------------------------------------------
// usage: one command transaction (cmd, position, count, data_byte) is taken
//   when req_valid is high and req_stall low; req_stall stays high while a
//   command is worked on. each command returns one result transaction
//   (status, read_byte, doc_length) held in an output register
// sequence from accept to rsp_valid: load, stage, length and unused codes
//   pass decide, the edit steps and remove; read scans one rotation of the
//   piece ring through the head cell, then decides and reads the store;
//   insert and delete scan, then pass decide, the edit steps and remove,
//   a delete dropping pieces one at a time in remove. next command: taken
//   in the cycle in which rsp_valid rises, never while one is worked on
// reset: synchronous, active high; empties the table and both stores, store
//   contents are not cleared and need no clearing pass
// stall: a waiting result does not block the next command; that one is
//   worked through and then waits with req_stall high until the result is taken
// ----------------------------------------------------------------------------
`default_nettype none

module piece_table_text_buffer (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // command transaction
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [ptb_pkg::CMD_W-1:0]     req_cmd,
   input  wire logic [ptb_pkg::POS_W-1:0]     req_position,
   input  wire logic [ptb_pkg::COUNT_W-1:0]   req_count,
   input  wire logic [ptb_pkg::BYTE_W-1:0]    req_data_byte,
   // result transaction
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [ptb_pkg::STATUS_W-1:0]       rsp_status,
   output logic [ptb_pkg::BYTE_W-1:0]         rsp_read_byte,
   output logic [ptb_pkg::POS_W-1:0]          rsp_doc_length
);

   // sequencer states
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SCAN   = 4'd1;
   localparam logic [3:0] S_DECIDE = 4'd2;
   localparam logic [3:0] S_OP1    = 4'd3;
   localparam logic [3:0] S_OP2    = 4'd4;
   localparam logic [3:0] S_OP3    = 4'd5;
   localparam logic [3:0] S_REMOVE = 4'd6;
   localparam logic [3:0] S_READ   = 4'd7;
   localparam logic [3:0] S_RDATA  = 4'd8;
   localparam logic [3:0] S_DONE   = 4'd9;

   localparam int ACC_W = ptb_pkg::ACC_W;
   localparam int CNT_W = ptb_pkg::CNT_W;
   localparam int LEN_W = ptb_pkg::LEN_W;
   localparam int OFF_W = ptb_pkg::OFF_W;

   // control state
   logic [3:0]                    state_ff, state_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [ACC_W-1:0]              total_ff, total_in;
   logic [ptb_pkg::ORIG_LW-1:0]   base_len_ff, base_len_in;
   logic [ptb_pkg::ADD_LW-1:0]    add_len_ff, add_len_in;
   logic                          edits_ff, edits_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   // captured command
   logic [ptb_pkg::CMD_W-1:0]     cmd_ff, cmd_in;
   logic [ptb_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic [ptb_pkg::COUNT_W-1:0]   cnt_ff, cnt_in;
   logic [ptb_pkg::BYTE_W-1:0]    byte_ff, byte_in;

   // scan results
   logic [ptb_pkg::IDX_W-1:0]     step_ff, step_in;
   logic [ACC_W-1:0]              acc_ff, acc_in;
   logic                          f0_ff, f0_in, f1_ff, f1_in, fr_ff, fr_in;
   logic [CNT_W-1:0]              idx0_ff, idx0_in, idx1_ff, idx1_in;
   logic [LEN_W-1:0]              off0_ff, off0_in, off1_ff, off1_in, roff_ff, roff_in;
   ptb_pkg::piece_type            p0_ff, p0_in, p1_ff, p1_in, rp_ff, rp_in;

   // edit plan
   ptb_pkg::cell_ctrl_type        plan1_ff, plan1_in, plan2_ff, plan2_in, plan3_ff, plan3_in;
   logic [CNT_W-1:0]              rem_n_ff, rem_n_in, rem_at_ff, rem_at_in;
   logic [ptb_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic [ptb_pkg::BYTE_W-1:0]    rbyte_ff, rbyte_in;

   // output payload
   logic [ptb_pkg::STATUS_W-1:0]  rsp_status_ff;
   logic [ptb_pkg::BYTE_W-1:0]    rsp_read_byte_ff;
   logic [ptb_pkg::POS_W-1:0]     rsp_doc_length_ff;

   // chain and stores
   ptb_pkg::cell_ctrl_type        ctrl;
   ptb_pkg::piece_type            head;
   logic                          orig_wr, add_wr, rd_en;
   logic [ptb_pkg::BYTE_W-1:0]    orig_q, add_q;

   // datapath helpers
   logic                          accept, out_free;
   logic                          slot_valid;
   logic [ACC_W-1:0]              pos_x, cnt_x, end_x, sum_x, rem_x, cnt_eff;
   logic                          interior0, interior1, same_piece;
   logic [CNT_W-1:0]              a_idx, b_idx, span;
   logic [CNT_W:0]                cnt_plus1, cnt_plus2, cnt_need;
   ptb_pkg::piece_type            np, trim0, frag0, frag1, load_piece;
   logic [ptb_pkg::RD_W-1:0]      rd_addr;
   logic                          rd_in_range;

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // positions and lengths in accumulator width
   assign pos_x      = ACC_W'(pos_ff);
   assign cnt_x      = ACC_W'(cnt_ff);
   assign end_x      = pos_x + cnt_x;
   assign sum_x      = acc_ff + ACC_W'(head.len);
   assign slot_valid = ({1'b0, step_ff} < count_ff);
   assign rem_x      = total_ff - pos_x;
   assign cnt_eff    = (cnt_x > rem_x) ? rem_x : cnt_x;

   // split decisions from the scan
   assign interior0  = (idx0_ff < count_ff) && (off0_ff != '0) && (off0_ff != p0_ff.len);
   assign interior1  = (idx1_ff < count_ff) && (off1_ff != '0) && (off1_ff != p1_ff.len);
   assign same_piece = interior0 && interior1 && (idx0_ff == idx1_ff);
   assign a_idx      = (off0_ff == '0) ? idx0_ff : idx0_ff + 1'b1;
   assign b_idx      = (idx1_ff >= count_ff) ? count_ff :
                       (off1_ff == p1_ff.len) ? idx1_ff + 1'b1 : idx1_ff;
   assign span       = b_idx - a_idx;
   assign cnt_plus1  = {1'b0, count_ff} + (CNT_W+1)'(1);
   assign cnt_plus2  = {1'b0, count_ff} + (CNT_W+1)'(2);
   assign cnt_need   = {1'b0, count_ff} + (CNT_W+1)'(interior0) + (CNT_W+1)'(interior1);

   // new and split pieces
   always_comb begin
      np.src        = 1'b1;
      np.off        = OFF_W'(ACC_W'(add_len_ff) - cnt_x);
      np.len        = LEN_W'(cnt_ff);
      trim0         = p0_ff;
      trim0.len     = off0_ff;
      frag0.src     = p0_ff.src;
      frag0.off     = p0_ff.off + OFF_W'(off0_ff);
      frag0.len     = p0_ff.len - off0_ff;
      frag1.src     = p1_ff.src;
      frag1.off     = p1_ff.off + OFF_W'(off1_ff);
      frag1.len     = p1_ff.len - off1_ff;
      load_piece    = head;
      load_piece.len = head.len + 1'b1;
      if (count_ff == '0) begin
         load_piece.src = 1'b0;
         load_piece.off = '0;
         load_piece.len = LEN_W'(1);
      end
   end

   // byte address for a read
   assign rd_addr     = ptb_pkg::RD_W'(rp_ff.off) + ptb_pkg::RD_W'(roff_ff);
   assign rd_in_range = rp_ff.src ? (rd_addr < ptb_pkg::RD_W'(ptb_pkg::ADD_DEPTH))
                                  : (rd_addr < ptb_pkg::RD_W'(ptb_pkg::ORIG_DEPTH));
   assign rd_en       = (state_ff == S_READ);

   // cell control per state
   always_comb begin
      ctrl    = '0;
      ctrl.op = ptb_pkg::OP_HOLD;
      unique case (state_ff)
         S_SCAN:   ctrl.op = ptb_pkg::OP_ROTATE;
         S_OP1:    ctrl = plan1_ff;
         S_OP2:    ctrl = plan2_ff;
         S_OP3:    ctrl = plan3_ff;
         S_REMOVE: begin
            if (rem_n_ff != '0) begin
               ctrl.op = ptb_pkg::OP_REMOVE;
               ctrl.at = rem_at_ff;
            end
         end
         default:  ctrl.op = ptb_pkg::OP_HOLD;
      endcase
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      total_in    = total_ff;
      base_len_in = base_len_ff;
      add_len_in  = add_len_ff;
      edits_in    = edits_ff;
      cmd_in      = cmd_ff;
      pos_in      = pos_ff;
      cnt_in      = cnt_ff;
      byte_in     = byte_ff;
      step_in     = step_ff;
      acc_in      = acc_ff;
      f0_in       = f0_ff;
      f1_in       = f1_ff;
      fr_in       = fr_ff;
      idx0_in     = idx0_ff;
      idx1_in     = idx1_ff;
      off0_in     = off0_ff;
      off1_in     = off1_ff;
      roff_in     = roff_ff;
      p0_in       = p0_ff;
      p1_in       = p1_ff;
      rp_in       = rp_ff;
      plan1_in    = plan1_ff;
      plan2_in    = plan2_ff;
      plan3_in    = plan3_ff;
      rem_n_in    = rem_n_ff;
      rem_at_in   = rem_at_ff;
      status_in   = status_ff;
      rbyte_in    = rbyte_ff;
      orig_wr     = 1'b0;
      add_wr      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in  = req_cmd;
               pos_in  = req_position;
               cnt_in  = req_count;
               byte_in = req_data_byte;
               step_in = '0;
               acc_in  = '0;
               f0_in   = 1'b0;
               f1_in   = 1'b0;
               fr_in   = 1'b0;
               idx0_in = count_ff;
               idx1_in = count_ff;
               off0_in = '0;
               off1_in = '0;
               if (req_cmd == ptb_pkg::CMD_INSERT || req_cmd == ptb_pkg::CMD_DELETE ||
                   req_cmd == ptb_pkg::CMD_READ) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_DECIDE;
               end
            end
         end

         // one piece per cycle passes the head; first hits win
         S_SCAN: begin
            if (slot_valid) begin
               if (!f0_ff && (pos_x <= sum_x)) begin
                  f0_in   = 1'b1;
                  idx0_in = {1'b0, step_ff};
                  off0_in = LEN_W'(pos_x - acc_ff);
                  p0_in   = head;
               end
               if (!f1_ff && (end_x <= sum_x)) begin
                  f1_in   = 1'b1;
                  idx1_in = {1'b0, step_ff};
                  off1_in = LEN_W'(end_x - acc_ff);
                  p1_in   = head;
               end
               if (!fr_ff && (pos_x < sum_x)) begin
                  fr_in   = 1'b1;
                  roff_in = LEN_W'(pos_x - acc_ff);
                  rp_in   = head;
               end
               acc_in = sum_x;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == ptb_pkg::IDX_W'(ptb_pkg::MAX_PIECES - 1)) begin
               state_in = S_DECIDE;
            end
         end

         S_DECIDE: begin
            status_in = ptb_pkg::ST_OK;
            rbyte_in  = '0;
            plan1_in  = '0;
            plan2_in  = '0;
            plan3_in  = '0;
            plan1_in.op = ptb_pkg::OP_HOLD;
            plan2_in.op = ptb_pkg::OP_HOLD;
            plan3_in.op = ptb_pkg::OP_HOLD;
            rem_n_in  = '0;
            rem_at_in = a_idx;
            state_in  = S_OP1;
            unique case (cmd_ff)
               ptb_pkg::CMD_LOAD: begin
                  if (edits_ff) begin
                     status_in = ptb_pkg::ST_RANGE;
                  end else if (base_len_ff >= ptb_pkg::ORIG_LW'(ptb_pkg::ORIG_DEPTH)) begin
                     status_in = ptb_pkg::ST_STORE_FULL;
                  end else begin
                     orig_wr           = 1'b1;
                     base_len_in       = base_len_ff + 1'b1;
                     total_in          = total_ff + 1'b1;
                     plan1_in.op       = ptb_pkg::OP_WRITE;
                     plan1_in.at       = '0;
                     plan1_in.wdata    = load_piece;
                     if (count_ff == '0) begin
                        count_in = CNT_W'(1);
                     end
                  end
               end
               ptb_pkg::CMD_STAGE: begin
                  if (add_len_ff >= ptb_pkg::ADD_LW'(ptb_pkg::ADD_DEPTH)) begin
                     status_in = ptb_pkg::ST_STORE_FULL;
                  end else begin
                     add_wr     = 1'b1;
                     add_len_in = add_len_ff + 1'b1;
                  end
               end
               ptb_pkg::CMD_INSERT: begin
                  edits_in = 1'b1;
                  if (cnt_ff == '0) begin
                     status_in = ptb_pkg::ST_OK;
                  end else if (cnt_x > ACC_W'(add_len_ff)) begin
                     status_in = ptb_pkg::ST_STORE_FULL;
                  end else if (interior0) begin
                     // split the piece and put the new one between the halves
                     if (cnt_plus2 > (CNT_W+1)'(ptb_pkg::MAX_PIECES)) begin
                        status_in = ptb_pkg::ST_TABLE_FULL;
                     end else begin
                        plan1_in.op    = ptb_pkg::OP_WRITE;
                        plan1_in.at    = idx0_ff;
                        plan1_in.wdata = trim0;
                        plan2_in.op    = ptb_pkg::OP_OPEN;
                        plan2_in.at    = idx0_ff + CNT_W'(1);
                        plan2_in.wdata = np;
                        plan3_in.op    = ptb_pkg::OP_OPEN;
                        plan3_in.at    = idx0_ff + CNT_W'(2);
                        plan3_in.wdata = frag0;
                        count_in       = count_ff + CNT_W'(2);
                        total_in       = total_ff + cnt_x;
                     end
                  end else if (cnt_plus1 > (CNT_W+1)'(ptb_pkg::MAX_PIECES)) begin
                     status_in = ptb_pkg::ST_TABLE_FULL;
                  end else begin
                     plan1_in.op    = ptb_pkg::OP_OPEN;
                     plan1_in.at    = a_idx;
                     plan1_in.wdata = np;
                     count_in       = count_ff + CNT_W'(1);
                     total_in       = total_ff + cnt_x;
                  end
               end
               ptb_pkg::CMD_DELETE: begin
                  edits_in = 1'b1;
                  if (cnt_ff == '0) begin
                     status_in = ptb_pkg::ST_OK;
                  end else if (pos_x >= total_ff) begin
                     status_in = ptb_pkg::ST_RANGE;
                  end else if (cnt_need > (CNT_W+1)'(ptb_pkg::MAX_PIECES)) begin
                     status_in = ptb_pkg::ST_TABLE_FULL;
                  end else begin
                     total_in = total_ff - cnt_eff;
                     if (interior0) begin
                        plan1_in.op    = ptb_pkg::OP_WRITE;
                        plan1_in.at    = idx0_ff;
                        plan1_in.wdata = trim0;
                     end
                     if (same_piece) begin
                        // range inside one piece: head and tail both stay
                        plan2_in.op    = ptb_pkg::OP_OPEN;
                        plan2_in.at    = idx0_ff + CNT_W'(1);
                        plan2_in.wdata = frag1;
                        count_in       = count_ff + CNT_W'(1);
                     end else begin
                        if (interior1) begin
                           plan2_in.op    = ptb_pkg::OP_WRITE;
                           plan2_in.at    = idx1_ff;
                           plan2_in.wdata = frag1;
                        end
                        rem_n_in = span;
                        count_in = count_ff - span;
                     end
                  end
               end
               ptb_pkg::CMD_READ: begin
                  status_in = fr_ff ? ptb_pkg::ST_OK : ptb_pkg::ST_RANGE;
                  state_in  = S_READ;
               end
               ptb_pkg::CMD_LENGTH: begin
                  status_in = ptb_pkg::ST_OK;
               end
               default: begin
                  status_in = ptb_pkg::ST_RANGE;
               end
            endcase
         end

         S_OP1: state_in = S_OP2;
         S_OP2: state_in = S_OP3;
         S_OP3: state_in = S_REMOVE;

         S_REMOVE: begin
            if (rem_n_ff != '0) begin
               rem_n_in = rem_n_ff - 1'b1;
            end else begin
               state_in = S_DONE;
            end
         end

         S_READ: state_in = S_RDATA;

         S_RDATA: begin
            if (fr_ff && rd_in_range) begin
               rbyte_in = rp_ff.src ? add_q : orig_q;
            end else begin
               rbyte_in = '0;
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (state_ff == S_DONE && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         base_len_ff  <= '0;
         add_len_ff   <= '0;
         edits_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         base_len_ff  <= base_len_in;
         add_len_ff   <= add_len_in;
         edits_ff     <= edits_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      pos_ff    <= pos_in;
      cnt_ff    <= cnt_in;
      byte_ff   <= byte_in;
      step_ff   <= step_in;
      acc_ff    <= acc_in;
      f0_ff     <= f0_in;
      f1_ff     <= f1_in;
      fr_ff     <= fr_in;
      idx0_ff   <= idx0_in;
      idx1_ff   <= idx1_in;
      off0_ff   <= off0_in;
      off1_ff   <= off1_in;
      roff_ff   <= roff_in;
      p0_ff     <= p0_in;
      p1_ff     <= p1_in;
      rp_ff     <= rp_in;
      plan1_ff  <= plan1_in;
      plan2_ff  <= plan2_in;
      plan3_ff  <= plan3_in;
      rem_n_ff  <= rem_n_in;
      rem_at_ff <= rem_at_in;
      status_ff <= status_in;
      rbyte_ff  <= rbyte_in;
      if (state_ff == S_DONE && out_free) begin
         rsp_status_ff     <= status_ff;
         rsp_read_byte_ff  <= rbyte_ff;
         rsp_doc_length_ff <= total_ff[ptb_pkg::POS_W-1:0];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_byte  = rsp_read_byte_ff;
   assign rsp_doc_length = rsp_doc_length_ff;

   // piece cells
   ptb_chain u_chain (
      .clock (clock),
      .ctrl  (ctrl),
      .head  (head)
   );

   // original bytes, appended by load
   ptb_ram #(
      .DEPTH (ptb_pkg::ORIG_DEPTH),
      .WIDTH (ptb_pkg::BYTE_W)
   ) u_orig (
      .clock   (clock),
      .wr_en   (orig_wr),
      .wr_addr (base_len_ff[ptb_pkg::ORIG_AW-1:0]),
      .wr_data (byte_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr[ptb_pkg::ORIG_AW-1:0]),
      .rd_data (orig_q)
   );

   // add bytes, appended by stage
   ptb_ram #(
      .DEPTH (ptb_pkg::ADD_DEPTH),
      .WIDTH (ptb_pkg::BYTE_W)
   ) u_add (
      .clock   (clock),
      .wr_en   (add_wr),
      .wr_addr (add_len_ff[ptb_pkg::ADD_AW-1:0]),
      .wr_data (byte_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr[ptb_pkg::ADD_AW-1:0]),
      .rd_data (add_q)
   );

endmodule

`default_nettype wire
